// File: rtl/duf_pkg.sv
// shared types and constants for the desk uart frame handler
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package duf_pkg;

    // frame header and button packet bytes
    localparam logic [7:0] HDR_ACT   = 8'h99;
    localparam logic [7:0] HDR_TGT   = 8'h98;
    localparam logic [7:0] BTN_SYNC  = 8'hD8;
    localparam logic [7:0] BTN_CMD   = 8'h78;

    // idle counter limits
    localparam logic [15:0] IDLE_MAX      = 16'hFFFF;
    localparam logic [15:0] TIMEOUT_RESET = 16'd1000;

    // frame lengths after the header byte
    localparam logic [2:0] ACT_DATA_BYTES = 3'd3;
    localparam logic [2:0] TGT_DATA_BYTES = 3'd4;

    // inch conversion: cm*12800/127 = cm*100 + floor(cm*100/127)
    localparam logic [14:0] CM_SCALE  = 15'd100;
    localparam logic [14:0] INCH_DIV  = 15'd127;
    // cm*100*2064, quotient estimate taken from bit 18 upward
    localparam logic [25:0] PROD_MUL  = 26'd206400;
    localparam int          PROD_SHIFT = 18;

    // command queue depth
    localparam int CMD_DEPTH = 4;
    localparam int CMD_AW    = $clog2(CMD_DEPTH);

    // result word kinds
    typedef enum logic [2:0] {
        KIND_TX        = 3'd0,
        KIND_ACTUAL    = 3'd1,
        KIND_TARGET    = 3'd2,
        KIND_SUM_FAIL  = 3'd3,
        KIND_PAIR_FAIL = 3'd4
    } t_kind;

    // work handed from the front to the back
    typedef struct packed {
        logic       has_report;
        t_kind      rep_kind;
        logic [7:0] cm;
        logic [7:0] motion;
        logic       has_buttons;
        logic [7:0] button;
    } t_cmd;

endpackage

`default_nettype wire

// File: rtl/duf_front.sv
// front end: frame parsing, idle counter and wake decision
// depends on duf_pkg; emits one command per item that causes results
`timescale 1ns / 1ps
`default_nettype none

module duf_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_accept,
    input  wire logic          i_req_type,
    input  wire logic [7:0]    i_rx_byte,
    input  wire logic [7:0]    i_button_code,
    input  wire logic          i_cfg_we,
    input  wire logic [15:0]   i_cfg_data,
    output logic               o_cmd_valid,
    output duf_pkg::t_cmd      o_cmd
);
    import duf_pkg::*;

    typedef enum logic [2:0] {
        MODE_IDLE = 3'b001,
        MODE_ACT  = 3'b010,
        MODE_TGT  = 3'b100
    } t_mode;

    t_mode       r_mode, n_mode;
    logic [2:0]  r_cnt, n_cnt;
    logic [7:0]  r_fb [4];
    logic [7:0]  r_actual, n_actual;
    logic [7:0]  r_target, n_target;
    logic [15:0] r_idle, n_idle;
    logic [15:0] r_timeout;
    logic        fb_we;
    logic [15:0] tick_inc;
    logic [7:0]  sum;
    t_cmd        cmd;

    // next state and command
    always_comb begin
        n_mode   = r_mode;
        n_cnt    = r_cnt;
        n_actual = r_actual;
        n_target = r_target;
        n_idle   = r_idle;
        fb_we    = 1'b0;
        cmd      = '0;
        cmd.rep_kind = KIND_TX;
        cmd.button   = i_button_code;
        tick_inc = (r_idle == IDLE_MAX) ? r_idle : r_idle + 16'd1;
        sum      = HDR_ACT + r_fb[0] + r_fb[1] + r_fb[2];
        if (i_accept) begin
            if (i_req_type) begin
                // tick: count idle time, wake the link when it has slept and a button is pressed or no target is set
                if (tick_inc >= r_timeout && (i_button_code != 8'd0 || r_target == 8'd0)) begin
                    cmd.has_buttons = 1'b1;
                    n_idle          = '0;
                end else begin
                    n_idle = tick_inc;
                end
            end else begin
                n_idle = '0;
                unique case (r_mode)
                    MODE_IDLE: begin
                        if (i_rx_byte == HDR_ACT) begin
                            n_mode = MODE_ACT;
                            n_cnt  = '0;
                        end else if (i_rx_byte == HDR_TGT) begin
                            n_mode = MODE_TGT;
                            n_cnt  = '0;
                        end
                    end
                    MODE_ACT: begin
                        if (r_cnt < ACT_DATA_BYTES) begin
                            fb_we = 1'b1;
                            n_cnt = r_cnt + 3'd1;
                        end else begin
                            cmd.has_report = 1'b1;
                            if (sum == i_rx_byte) begin
                                n_actual     = r_fb[2];
                                cmd.rep_kind = KIND_ACTUAL;
                                cmd.cm       = r_fb[2];
                                cmd.motion   = r_fb[0];
                            end else begin
                                cmd.rep_kind = KIND_SUM_FAIL;
                            end
                            n_mode = MODE_IDLE;
                            n_cnt  = '0;
                        end
                    end
                    MODE_TGT: begin
                        if (r_cnt < TGT_DATA_BYTES) begin
                            fb_we = 1'b1;
                            n_cnt = r_cnt + 3'd1;
                        end else begin
                            cmd.has_report  = 1'b1;
                            cmd.has_buttons = 1'b1;
                            if (r_fb[0] == HDR_TGT && r_fb[1] == r_fb[2]
                                && r_fb[3] == i_rx_byte) begin
                                n_target     = r_fb[3];
                                cmd.rep_kind = KIND_TARGET;
                                cmd.cm       = r_fb[3];
                            end else begin
                                cmd.rep_kind = KIND_PAIR_FAIL;
                            end
                            n_mode = MODE_IDLE;
                            n_cnt  = '0;
                        end
                    end
                    default: begin
                        n_mode = MODE_IDLE;
                        n_cnt  = '0;
                    end
                endcase
            end
        end
    end

    assign o_cmd_valid = i_accept && (cmd.has_report || cmd.has_buttons);
    assign o_cmd       = cmd;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_IDLE;
            r_cnt     <= '0;
            r_actual  <= '0;
            r_target  <= '0;
            r_idle    <= '0;
            r_timeout <= TIMEOUT_RESET;
        end else begin
            r_mode   <= n_mode;
            r_cnt    <= n_cnt;
            r_actual <= n_actual;
            r_target <= n_target;
            r_idle   <= n_idle;
            if (i_cfg_we) begin
                r_timeout <= i_cfg_data;
            end
        end
    end

    // frame byte store, no reset
    always_ff @(posedge i_clk) begin
        if (fb_we) begin
            r_fb[r_cnt[1:0]] <= i_rx_byte;
        end
    end

endmodule

`default_nettype wire

// File: rtl/duf_cmd_fifo.sv
// short command queue between front and back
// depends on duf_pkg for the command type and depth
`timescale 1ns / 1ps
`default_nettype none

module duf_cmd_fifo (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire duf_pkg::t_cmd i_data,
    output logic               o_full,
    input  wire logic          i_pop,
    output logic               o_valid,
    output duf_pkg::t_cmd      o_data
);
    import duf_pkg::*;

    t_cmd              r_mem [CMD_DEPTH];
    logic [CMD_AW-1:0] r_wr, r_rd;
    logic [CMD_AW:0]   r_count;
    logic              do_push, do_pop;

    assign o_full  = (r_count == (CMD_AW+1)'(CMD_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_count <= r_count + (CMD_AW+1)'(do_push) - (CMD_AW+1)'(do_pop);
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

`default_nettype wire

// File: rtl/duf_back.sv
// back end: inch conversion and expansion of commands into result words
// depends on duf_pkg; drives the registered result port
`timescale 1ns / 1ps
`default_nettype none

module duf_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cmd_valid,
    input  wire duf_pkg::t_cmd i_cmd,
    output logic               o_cmd_pop,
    output logic               o_valid,
    input  wire logic          i_pop,
    output logic [2:0]         o_kind,
    output logic [7:0]         o_tx_byte,
    output logic [7:0]         o_height_cm,
    output logic [14:0]        o_height_in_q8,
    output logic [7:0]         o_motion,
    output logic               o_last
);
    import duf_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MUL  = 4'b0010,
        S_DIV  = 4'b0100,
        S_EMIT = 4'b1000
    } t_state;

    localparam logic [2:0] BEAT_REPORT = 3'd0;
    localparam logic [2:0] BEAT_SYNC0  = 3'd1;
    localparam logic [2:0] BEAT_SYNC1  = 3'd2;
    localparam logic [2:0] BEAT_CMD    = 3'd3;
    localparam logic [2:0] BEAT_BTN0   = 3'd4;
    localparam logic [2:0] BEAT_BTN1   = 3'd5;

    t_state      r_state, n_state;
    t_cmd        r_cmd, n_cmd;
    logic [25:0] r_prod, n_prod;
    logic [14:0] r_inch, n_inch;
    logic [2:0]  r_beat, n_beat;
    logic        r_out_valid, n_out_valid;
    logic [2:0]  r_kind, n_kind;
    logic [7:0]  r_tx, n_tx;
    logic [7:0]  r_cm, n_cm;
    logic [14:0] r_inq, n_inq;
    logic [7:0]  r_mot, n_mot;
    logic        r_last, n_last;

    logic        emit_ok;
    logic [7:0]  q0;
    logic [14:0] y, rem;
    logic        beat_last;

    assign emit_ok = !r_out_valid || i_pop;

    // remainder correction of the quotient estimate
    always_comb begin
        y   = 15'(r_cmd.cm) * CM_SCALE;
        q0  = r_prod[PROD_SHIFT +: 8];
        rem = y - 15'(q0) * INCH_DIV;
    end

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_prod      = r_prod;
        n_inch      = r_inch;
        n_beat      = r_beat;
        n_out_valid = r_out_valid && !i_pop;
        n_kind      = r_kind;
        n_tx        = r_tx;
        n_cm        = r_cm;
        n_inq       = r_inq;
        n_mot       = r_mot;
        n_last      = r_last;
        o_cmd_pop   = 1'b0;
        beat_last   = (r_beat == BEAT_BTN1) || (r_beat == BEAT_REPORT && !r_cmd.has_buttons);
        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    n_cmd     = i_cmd;
                    n_state   = S_MUL;
                end
            end
            S_MUL: begin
                n_prod  = 26'(r_cmd.cm) * PROD_MUL;
                n_state = S_DIV;
            end
            S_DIV: begin
                n_inch  = y + 15'(q0) + 15'(rem >= INCH_DIV);
                n_beat  = r_cmd.has_report ? BEAT_REPORT : BEAT_SYNC0;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (emit_ok) begin
                    // load one word into the output register
                    n_out_valid = 1'b1;
                    n_last      = beat_last;
                    n_kind      = KIND_TX;
                    n_tx        = '0;
                    n_cm        = '0;
                    n_inq       = '0;
                    n_mot       = '0;
                    unique case (r_beat)
                        BEAT_REPORT: begin
                            n_kind = r_cmd.rep_kind;
                            n_cm   = r_cmd.cm;
                            n_inq  = r_inch;
                            n_mot  = r_cmd.motion;
                        end
                        BEAT_SYNC0, BEAT_SYNC1: n_tx = BTN_SYNC;
                        BEAT_CMD:               n_tx = BTN_CMD;
                        BEAT_BTN0, BEAT_BTN1:   n_tx = r_cmd.button;
                        default:                n_tx = '0;
                    endcase
                    if (beat_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_beat = r_beat + 3'd1;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_cmd  <= n_cmd;
        r_prod <= n_prod;
        r_inch <= n_inch;
        r_beat <= n_beat;
        r_kind <= n_kind;
        r_tx   <= n_tx;
        r_cm   <= n_cm;
        r_inq  <= n_inq;
        r_mot  <= n_mot;
        r_last <= n_last;
    end

    assign o_valid        = r_out_valid;
    assign o_kind         = r_kind;
    assign o_tx_byte      = r_tx;
    assign o_height_cm    = r_cm;
    assign o_height_in_q8 = r_inq;
    assign o_motion       = r_mot;
    assign o_last         = r_last;

endmodule

`default_nettype wire

// File: rtl/desk_uart_frame_handler_unit.sv
// Desk UART frame handler. Input words are received bytes or millisecond
// ticks; the front parses 0x99 and 0x98 frames, runs the idle/wake counter
// and takes a new word every cycle while its four-entry command queue has
// room. The back pulls one command at a time, runs the cm-to-inch conversion
// (one constant multiply, then a correction step) and then gives one result
// word per cycle into the output register while pop keeps up; a command
// gives n result words (n up to 6: report plus five-byte button packet). The
// wake timeout register is always ready and should be written while the block
// is idle. Depends on duf_pkg, duf_front, duf_cmd_fifo and duf_back.
`timescale 1ns / 1ps
`default_nettype none

module desk_uart_frame_handler_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic        i_req_type,
    input  wire logic [7:0]  i_rx_byte,
    input  wire logic [7:0]  i_button_code,
    output logic             empty,
    input  wire logic        pop,
    output logic [2:0]       o_kind,
    output logic [7:0]       o_tx_byte,
    output logic [7:0]       o_height_cm,
    output logic [14:0]      o_height_in_q8,
    output logic [7:0]       o_motion,
    output logic             o_last,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [15:0] i_cfg_data
);
    import duf_pkg::*;

    logic accept;
    logic front_valid;
    t_cmd front_cmd;
    logic q_valid, q_pop;
    t_cmd q_cmd;
    logic out_valid;

    assign accept      = push && !full;
    assign o_cfg_ready = 1'b1;
    assign empty       = !out_valid;

    // parser and wake logic
    duf_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_req_type    (i_req_type),
        .i_rx_byte     (i_rx_byte),
        .i_button_code (i_button_code),
        .i_cfg_we      (i_cfg_valid),
        .i_cfg_data    (i_cfg_data),
        .o_cmd_valid   (front_valid),
        .o_cmd         (front_cmd)
    );

    // command queue
    duf_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_valid),
        .i_data  (front_cmd),
        .o_full  (full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_cmd)
    );

    // result word generation
    duf_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd_valid    (q_valid),
        .i_cmd          (q_cmd),
        .o_cmd_pop      (q_pop),
        .o_valid        (out_valid),
        .i_pop          (pop),
        .o_kind         (o_kind),
        .o_tx_byte      (o_tx_byte),
        .o_height_cm    (o_height_cm),
        .o_height_in_q8 (o_height_in_q8),
        .o_motion       (o_motion),
        .o_last         (o_last)
    );

endmodule

`default_nettype wire

// File: bench/duf_reply_checker.sv
// reply checker for the desk uart frame handler: watches the word, reply and
// wake timeout channels, predicts every reply word and compares in order
// depends on duf_pkg for the reply kinds and frame constants
`timescale 1ns / 1ps

module duf_reply_checker
    import duf_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_push,
    input  wire logic        i_full,
    input  wire logic        i_req_type,
    input  wire logic [7:0]  i_rx_byte,
    input  wire logic [7:0]  i_button_code,
    input  wire logic        i_empty,
    input  wire logic        i_pop,
    input  wire logic [2:0]  i_kind,
    input  wire logic [7:0]  i_tx_byte,
    input  wire logic [7:0]  i_height_cm,
    input  wire logic [14:0] i_height_in_q8,
    input  wire logic [7:0]  i_motion,
    input  wire logic        i_last,
    input  wire logic        i_cfg_valid,
    input  wire logic        i_cfg_ready,
    input  wire logic [15:0] i_cfg_data,
    output int               o_errors,
    output int               o_pending
);

    typedef enum logic [1:0] {
        PARSE_SCAN,
        PARSE_ACTUAL,
        PARSE_TARGET
    } t_parse_mode;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  tx;
        logic [7:0]  cm;
        logic [14:0] inch;
        logic [7:0]  motion;
        logic        last;
    } t_reply;

    // shadow of the block state
    logic [15:0] wake_timeout;
    t_parse_mode parse_mode;
    logic [2:0]  data_count;
    logic [7:0]  frame_data [0:4];
    logic [7:0]  actual_cm;
    logic [7:0]  target_cm;
    logic [15:0] idle_ticks;

    t_reply replies_due [$];
    int     mismatches = 0;

    assign o_errors = mismatches;

    initial o_pending = 0;

    // floor(cm * 12800 / 127), Q7.8 inches
    function automatic logic [14:0] cm_to_inch_q8(input logic [7:0] cm);
        int unsigned scaled;
        scaled = cm;
        scaled = (scaled * 12800) / 127;
        return scaled[14:0];
    endfunction

    function automatic t_reply make_reply(input t_kind kind, input logic [7:0] tx,
                                          input logic [7:0] cm, input logic [7:0] motion);
        t_reply r;
        r.kind   = kind;
        r.tx     = tx;
        r.cm     = cm;
        r.inch   = (kind == KIND_ACTUAL || kind == KIND_TARGET) ? cm_to_inch_q8(cm) : 15'd0;
        r.motion = motion;
        r.last   = 1'b0;
        return r;
    endfunction

    // advance the shadow state by one word and queue the replies it causes
    function automatic void parse_word(input logic rt, input logic [7:0] rx,
                                       input logic [7:0] btn);
        t_reply     batch [0:5];
        t_reply     r;
        int         n;
        logic       packet;
        logic [7:0] sum;
        n      = 0;
        packet = 1'b0;
        if (rt) begin
            if (idle_ticks != IDLE_MAX)
                idle_ticks = idle_ticks + 16'd1;
            if (idle_ticks >= wake_timeout && (btn != 8'd0 || target_cm == 8'd0)) begin
                packet     = 1'b1;
                idle_ticks = 16'd0;
            end
        end else begin
            idle_ticks = 16'd0;
            case (parse_mode)
                PARSE_SCAN: begin
                    data_count = 3'd0;
                    if (rx == HDR_ACT)
                        parse_mode = PARSE_ACTUAL;
                    else if (rx == HDR_TGT)
                        parse_mode = PARSE_TARGET;
                end
                PARSE_ACTUAL: begin
                    if (data_count < ACT_DATA_BYTES) begin
                        frame_data[data_count] = rx;
                        data_count = data_count + 3'd1;
                    end else begin
                        sum = HDR_ACT + frame_data[0] + frame_data[1] + frame_data[2];
                        if (sum == rx) begin
                            actual_cm = frame_data[2];
                            batch[n]  = make_reply(KIND_ACTUAL, 8'd0, actual_cm,
                                                   frame_data[0]);
                            n++;
                        end else begin
                            batch[n] = make_reply(KIND_SUM_FAIL, 8'd0, 8'd0, 8'd0);
                            n++;
                        end
                        parse_mode = PARSE_SCAN;
                        data_count = 3'd0;
                    end
                end
                PARSE_TARGET: begin
                    if (data_count < TGT_DATA_BYTES) begin
                        frame_data[data_count] = rx;
                        data_count = data_count + 3'd1;
                    end else begin
                        if (frame_data[0] == HDR_TGT && frame_data[1] == frame_data[2]
                            && frame_data[3] == rx) begin
                            target_cm = frame_data[3];
                            batch[n]  = make_reply(KIND_TARGET, 8'd0, target_cm, 8'd0);
                            n++;
                        end else begin
                            batch[n] = make_reply(KIND_PAIR_FAIL, 8'd0, 8'd0, 8'd0);
                            n++;
                        end
                        packet     = 1'b1;
                        parse_mode = PARSE_SCAN;
                        data_count = 3'd0;
                    end
                end
                default: begin
                    parse_mode = PARSE_SCAN;
                    data_count = 3'd0;
                end
            endcase
        end
        // button packet: sync, sync, command, then the button byte twice
        if (packet) begin
            batch[n] = make_reply(KIND_TX, BTN_SYNC, 8'd0, 8'd0);
            n++;
            batch[n] = make_reply(KIND_TX, BTN_SYNC, 8'd0, 8'd0);
            n++;
            batch[n] = make_reply(KIND_TX, BTN_CMD, 8'd0, 8'd0);
            n++;
            batch[n] = make_reply(KIND_TX, btn, 8'd0, 8'd0);
            n++;
            batch[n] = make_reply(KIND_TX, btn, 8'd0, 8'd0);
            n++;
        end
        for (int i = 0; i < n; i++) begin
            r      = batch[i];
            r.last = (i == n - 1);
            replies_due.push_back(r);
        end
    endfunction

    function automatic void check_field(input string what, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, what, want, got);
            mismatches++;
        end
    endfunction

    // sample all channels at the rising edge
    always @(posedge i_clk) begin : watch
        t_reply got;
        t_reply want;
        if (!i_rst_n) begin
            wake_timeout = TIMEOUT_RESET;
            parse_mode   = PARSE_SCAN;
            data_count   = 3'd0;
            actual_cm    = 8'd0;
            target_cm    = 8'd0;
            idle_ticks   = 16'd0;
            for (int i = 0; i < 5; i++)
                frame_data[i] = 8'd0;
            replies_due.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready)
                wake_timeout = i_cfg_data;
            if (i_push && !i_full)
                parse_word(i_req_type, i_rx_byte, i_button_code);
            if (i_pop && !i_empty) begin
                got = {t_kind'(i_kind), i_tx_byte, i_height_cm, i_height_in_q8,
                       i_motion, i_last};
                if (replies_due.size() == 0) begin
                    $display("%0t ns: reply word with none due, kind %0d tx %0h cm %0d",
                             $time, i_kind, i_tx_byte, i_height_cm);
                    mismatches++;
                end else begin
                    want = replies_due.pop_front();
                    check_field("kind", want.kind, got.kind);
                    check_field("tx_byte", want.tx, got.tx);
                    check_field("height_cm", want.cm, got.cm);
                    check_field("height_in_q8", want.inch, got.inch);
                    check_field("motion", want.motion, got.motion);
                    check_field("last", want.last, got.last);
                end
            end
        end
        o_pending <= replies_due.size();
    end

endmodule

// File: bench/testbench.sv
// top of the desk uart frame handler bench: clock, reset, word and reply traffic
// and wake timeout writes; depends on duf_pkg, the block and duf_reply_checker
`timescale 1ns / 1ps

module testbench;
    import duf_pkg::*;

    localparam int QUIET_LIMIT = 4000;
    localparam int DRAIN_WAIT  = 64;
    localparam int HOLD_CYCLES = 250;

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push    = 1'b0;
    logic        full;
    logic        req_type    = 1'b0;
    logic [7:0]  rx_byte     = 8'd0;
    logic [7:0]  button_code = 8'd0;
    logic        empty;
    logic        pop = 1'b0;
    logic [2:0]  kind;
    logic [7:0]  tx_byte;
    logic [7:0]  height_cm;
    logic [14:0] height_in_q8;
    logic [7:0]  motion;
    logic        last;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [15:0] cfg_data  = 16'd0;

    int errors;
    int pending;
    int words_offered = 0;
    int quiet_cycles  = 0;
    bit calm      = 1'b0;
    bit hold_req  = 1'b0;

    desk_uart_frame_handler_unit uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_req_type     (req_type),
        .i_rx_byte      (rx_byte),
        .i_button_code  (button_code),
        .empty          (empty),
        .pop            (pop),
        .o_kind         (kind),
        .o_tx_byte      (tx_byte),
        .o_height_cm    (height_cm),
        .o_height_in_q8 (height_in_q8),
        .o_motion       (motion),
        .o_last         (last),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (cfg_ready),
        .i_cfg_data     (cfg_data)
    );

    duf_reply_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (push),
        .i_full         (full),
        .i_req_type     (req_type),
        .i_rx_byte      (rx_byte),
        .i_button_code  (button_code),
        .i_empty        (empty),
        .i_pop          (pop),
        .i_kind         (kind),
        .i_tx_byte      (tx_byte),
        .i_height_cm    (height_cm),
        .i_height_in_q8 (height_in_q8),
        .i_motion       (motion),
        .i_last         (last),
        .i_cfg_valid    (cfg_valid),
        .i_cfg_ready    (cfg_ready),
        .i_cfg_data     (cfg_data),
        .o_errors       (errors),
        .o_pending      (pending)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // watchdog: cycles in which no word moves on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("testbench failed");
            $finish;
        end
    end

    // reply side: random stalls, or one long hold-off on request
    always @(negedge i_clk) begin
        if (hold_req) begin
            pop <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(negedge i_clk);
            hold_req = 1'b0;
        end else begin
            pop <= calm || ($urandom_range(0, 99) >= 26);
        end
    end

    // offer one word, idling at random first, and wait until it is taken
    task automatic offer_word(input logic rt, input logic [7:0] rx, input logic [7:0] btn);
        @(negedge i_clk);
        while (!calm && $urandom_range(0, 99) < 26) begin
            push <= 1'b0;
            @(negedge i_clk);
        end
        push        <= 1'b1;
        req_type    <= rt;
        rx_byte     <= rx;
        button_code <= btn;
        do @(posedge i_clk); while (full);
        words_offered++;
    endtask

    // height frame: header, motion, check byte, height, sum (mask spoils the sum)
    task automatic send_actual(input logic [7:0] mot, input logic [7:0] chk,
                               input logic [7:0] h, input logic [7:0] mask,
                               input logic [7:0] btn);
        logic [7:0] sum;
        sum = (HDR_ACT + mot + chk + h) ^ mask;
        offer_word(1'b0, HDR_ACT, btn);
        offer_word(1'b0, mot, btn);
        offer_word(1'b0, chk, btn);
        offer_word(1'b0, h, btn);
        offer_word(1'b0, sum, btn);
    endtask

    // target frame: three duplicated pairs, one byte spoilt when bad_pos is set
    task automatic send_target(input logic [7:0] a, input logic [7:0] h, input int bad_pos,
                               input logic [7:0] mask, input logic [7:0] btn);
        logic [7:0] frame [0:5];
        frame[0] = HDR_TGT;
        frame[1] = HDR_TGT;
        frame[2] = a;
        frame[3] = a;
        frame[4] = h;
        frame[5] = h;
        if (bad_pos > 0)
            frame[bad_pos] = frame[bad_pos] ^ mask;
        for (int i = 0; i < 6; i++)
            offer_word(1'b0, frame[i], btn);
    endtask

    function automatic logic [7:0] random_button();
        return ($urandom_range(0, 1) == 0) ? 8'd0 : 8'($urandom_range(0, 255));
    endfunction

    // mostly well-formed frames with random content, some ticks, noise and stubs
    task automatic random_traffic(input int n);
        int         stop_at;
        int         pick;
        logic [7:0] mot;
        stop_at = words_offered + n;
        while (words_offered < stop_at) begin
            pick = $urandom_range(0, 99);
            if (pick < 35) begin
                case ($urandom_range(0, 3))
                    0:       mot = 8'h40;
                    1:       mot = 8'h41;
                    2:       mot = 8'h42;
                    default: mot = 8'($urandom_range(0, 255));
                endcase
                send_actual(mot, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                            ($urandom_range(0, 99) < 25) ? 8'($urandom_range(1, 255)) : 8'd0,
                            random_button());
            end else if (pick < 65) begin
                send_target(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                            ($urandom_range(0, 99) < 35) ? $urandom_range(1, 5) : 0,
                            8'($urandom_range(1, 255)), random_button());
            end else if (pick < 80) begin
                repeat ($urandom_range(1, 4))
                    offer_word(1'b1, 8'($urandom_range(0, 255)), random_button());
            end else if (pick < 90) begin
                offer_word(1'b0, 8'($urandom_range(0, 255)), random_button());
            end else begin
                // header followed by a stub; the next frame lands inside it
                offer_word(1'b0, ($urandom_range(0, 1) == 0) ? HDR_ACT : HDR_TGT,
                           random_button());
                repeat ($urandom_range(1, 3))
                    offer_word(1'b0, 8'($urandom_range(0, 255)), random_button());
            end
        end
    endtask

    // stop offering, let every reply come out, then give the block time to go idle
    task automatic settle();
        @(negedge i_clk);
        push <= 1'b0;
        wait (pending == 0);
        repeat (DRAIN_WAIT) @(negedge i_clk);
    endtask

    task automatic write_timeout(input logic [15:0] value);
        @(negedge i_clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge i_clk); while (!cfg_ready);
        @(negedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        // reset
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: short timeout, target still zero
        write_timeout(16'd2);
        offer_word(1'b1, 8'h00, 8'h00);
        offer_word(1'b1, 8'hFF, 8'h00);
        send_actual(8'h41, 8'h00, 8'hFF, 8'h00, 8'hFF);
        // header bytes taken as data inside a frame, sum spoilt
        send_actual(8'h98, 8'h99, 8'h98, 8'h80, 8'h00);
        // good target of zero keeps the wake sends going
        send_target(8'hFF, 8'h00, 0, 8'h00, 8'h00);
        offer_word(1'b1, 8'h5A, 8'h00);
        offer_word(1'b1, 8'hA5, 8'h00);
        send_target(8'h00, 8'hB4, 0, 8'h00, 8'hA5);
        settle();

        // zero timeout: every tick counts as reached
        write_timeout(16'd0);
        offer_word(1'b1, 8'h00, 8'h00);
        offer_word(1'b1, 8'h00, 8'h3C);
        send_target(8'h11, 8'h00, 0, 8'h00, 8'h00);
        offer_word(1'b1, 8'h00, 8'h00);
        random_traffic(50);
        settle();

        // timeout of one with the receiver held off so the block fills up
        write_timeout(16'd1);
        hold_req = 1'b1;
        random_traffic(90);
        settle();

        // small random timeout, first with no idling on either side
        write_timeout(16'($urandom_range(3, 12)));
        calm = 1'b1;
        random_traffic(50);
        calm = 1'b0;
        random_traffic(60);
        settle();

        // largest timeout: a handful of ticks stays far below it
        write_timeout(16'hFFFF);
        send_target(8'h22, 8'h4D, 0, 8'h00, 8'h00);
        calm = 1'b1;
        repeat (10) offer_word(1'b1, 8'($urandom_range(0, 255)), 8'h00);
        offer_word(1'b1, 8'h00, 8'h5A);
        calm = 1'b0;
        random_traffic(40);
        settle();

        // back to the reset timeout
        write_timeout(TIMEOUT_RESET);
        random_traffic(20);
        settle();

        @(negedge i_clk);
        if (errors == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
